// File: design/ede_pkg.sv
// Shared constants and control types for the edit distance engine.
// No dependencies; used by ede_ctrl, ede_datapath and edit_distance_engine.
package ede_pkg;

   localparam int MAX_LEN_DEFAULT = 64;
   localparam int OP_W            = 2;
   localparam int CHAR_W          = 8;
   localparam int DIST_W          = 7;
   localparam int DIST_MAX        = 127;

   localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

   typedef struct packed {
      logic append_first;
      logic append_second;
      logic start;
      logic row_start;
      logic update;
      logic next_row;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic last_col;
      logic last_row;
   } status_type;

endpackage

// File: design/ede_ctrl.sv
// Sequencer for the edit distance engine: input handshake, row/cell stepping, result beat.
// Depends on ede_pkg; drives ede_datapath through cmd_type, reads status_type.
module ede_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ede_pkg::OP_W-1:0]    req_operation,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ede_pkg::cmd_type            cmd,
   input  ede_pkg::status_type         status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ROW  = 2'd1;
   localparam logic [1:0] S_CELL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == ede_pkg::OP_APPEND_FIRST) begin
                  cmd.append_first = 1'b1;
               end else if (req_operation == ede_pkg::OP_APPEND_SECOND) begin
                  cmd.append_second = 1'b1;
               end else if (req_operation == ede_pkg::OP_COMPUTE) begin
                  cmd.start = 1'b1;
                  state_in  = status.empty ? S_DONE : S_ROW;
               end
            end
         end
         S_ROW: begin
            cmd.row_start = 1'b1;
            state_in      = S_CELL;
         end
         S_CELL: begin
            cmd.update = 1'b1;
            if (status.last_col) begin
               if (status.last_row) begin
                  state_in = S_DONE;
               end else begin
                  cmd.next_row = 1'b1;
                  state_in     = S_ROW;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");

   a_empty_skip: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == ede_pkg::OP_COMPUTE && status.empty) |=> state_ff == S_DONE)
      else $error("empty word did not skip the sweep");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CELL && status.last_col && !status.last_row) |=> state_ff == S_ROW)
      else $error("row end did not start the next row");

   a_row_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW) |-> !status.empty)
      else $error("row sweep with an empty word");

endmodule

// File: design/ede_datapath.sv
// Datapath for the edit distance engine: word memories, score row memory, cell update.
// Depends on ede_pkg; stepped by ede_ctrl through cmd_type.
module ede_datapath #(
   parameter int MAX_LEN = ede_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ede_pkg::cmd_type              cmd,
   output ede_pkg::status_type           status,
   input  logic [ede_pkg::CHAR_W-1:0]    req_char_byte,
   output logic [ede_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_overflow
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int XW = (LW > ede_pkg::DIST_W) ? LW : ede_pkg::DIST_W;

   logic [ede_pkg::CHAR_W-1:0] mem_a [0:MAX_LEN-1];
   logic [ede_pkg::CHAR_W-1:0] mem_b [0:MAX_LEN-1];
   logic [LW-1:0]              mem_s [0:MAX_LEN];

   logic [LW-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic          ovf_seen_ff, ovf_seen_in;
   logic [LW-1:0] row_ff, col_ff, left_ff, diag_ff, res_ff;
   logic [ede_pkg::CHAR_W-1:0] a_rd_ff, b_rd_ff;
   logic [LW-1:0] s_rd_ff;
   logic [ede_pkg::DIST_W-1:0] dist_ff;
   logic          ovf_out_ff;

   logic          full_a, full_b, rd_en;
   logic [LW-1:0] rd_col, a_idx, b_idx, up, min_ab, min_v, cost;
   logic [XW-1:0] res_x;

   assign full_a = (len_a_ff == LW'(MAX_LEN));
   assign full_b = (len_b_ff == LW'(MAX_LEN));

   assign status.empty    = (len_a_ff == '0) || (len_b_ff == '0);
   assign status.last_col = (col_ff == len_b_ff);
   assign status.last_row = (row_ff == len_a_ff);

   assign rd_en  = cmd.row_start || (cmd.update && !status.last_col);
   assign rd_col = cmd.row_start ? LW'(1) : col_ff + LW'(1);
   assign a_idx  = row_ff - LW'(1);
   assign b_idx  = rd_col - LW'(1);

   assign up     = (row_ff == LW'(1)) ? col_ff : s_rd_ff;
   assign min_ab = (diag_ff < up) ? diag_ff : up;
   assign min_v  = (min_ab < left_ff) ? min_ab : left_ff;
   assign cost   = (a_rd_ff == b_rd_ff) ? diag_ff : min_v + LW'(1);

   assign res_x  = XW'(res_ff);

   always_comb begin
      len_a_in    = len_a_ff;
      len_b_in    = len_b_ff;
      ovf_seen_in = ovf_seen_ff;
      if (cmd.append_first) begin
         if (full_a) begin
            ovf_seen_in = 1'b1;
         end else begin
            len_a_in = len_a_ff + LW'(1);
         end
      end
      if (cmd.append_second) begin
         if (full_b) begin
            ovf_seen_in = 1'b1;
         end else begin
            len_b_in = len_b_ff + LW'(1);
         end
      end
      if (cmd.emit) begin
         len_a_in    = '0;
         len_b_in    = '0;
         ovf_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff    <= '0;
         len_b_ff    <= '0;
         ovf_seen_ff <= 1'b0;
      end else begin
         len_a_ff    <= len_a_in;
         len_b_ff    <= len_b_in;
         ovf_seen_ff <= ovf_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append_first && !full_a) begin
         mem_a[len_a_ff[AW-1:0]] <= req_char_byte;
      end
      if (cmd.append_second && !full_b) begin
         mem_b[len_b_ff[AW-1:0]] <= req_char_byte;
      end
      if (cmd.row_start) begin
         a_rd_ff <= mem_a[a_idx[AW-1:0]];
      end
      if (rd_en) begin
         b_rd_ff <= mem_b[b_idx[AW-1:0]];
         s_rd_ff <= mem_s[rd_col];
      end
      if (cmd.update) begin
         mem_s[col_ff] <= cost;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff <= LW'(1);
         res_ff <= len_a_ff + len_b_ff;
      end
      if (cmd.next_row) begin
         row_ff <= row_ff + LW'(1);
      end
      if (cmd.row_start) begin
         col_ff  <= LW'(1);
         left_ff <= row_ff;
         diag_ff <= row_ff - LW'(1);
      end
      if (cmd.update) begin
         col_ff  <= col_ff + LW'(1);
         left_ff <= cost;
         diag_ff <= up;
         res_ff  <= cost;
      end
      if (cmd.emit) begin
         dist_ff    <= (res_x > XW'(ede_pkg::DIST_MAX)) ?
                       ede_pkg::DIST_W'(ede_pkg::DIST_MAX) : res_x[ede_pkg::DIST_W-1:0];
         ovf_out_ff <= ovf_seen_ff;
      end
   end

   assign rsp_distance = dist_ff;
   assign rsp_overflow = ovf_out_ff;

endmodule

// File: design/edit_distance_engine.sv
// Edit distance engine top level. Append beats are taken back to back; a compute beat
// with both words loaded sweeps the score rows (one cell update per cycle along each
// row) and then raises rsp_valid, while an empty word skips the sweep; an untaken
// earlier result holds the new one back. req_ready stays low meanwhile.
// Reset clears the lengths, overflow flag, state and output valid; the word and
// score row memories keep their contents and need no clearing pass.
module edit_distance_engine #(
   parameter int MAX_LEN = ede_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ede_pkg::OP_W-1:0]      req_operation,
   input  logic [ede_pkg::CHAR_W-1:0]    req_char_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ede_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_overflow
);

   ede_pkg::cmd_type    cmd;
   ede_pkg::status_type status;

   ede_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .status        (status)
   );

   ede_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_char_byte (req_char_byte),
      .rsp_distance  (rsp_distance),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

// File: tb/edit_distance_checker.sv
// Scoreboard for the edit distance engine: mirrors both words from accepted request
// beats, predicts the distance and overflow flag of each compute beat, and checks them.
// Depends on ede_pkg for widths and operation codes.
module edit_distance_checker #(
   parameter int MAX_LEN = ede_pkg::MAX_LEN_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [ede_pkg::OP_W-1:0]   req_operation,
   input  logic [ede_pkg::CHAR_W-1:0] req_char_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [ede_pkg::DIST_W-1:0] rsp_distance,
   input  logic                       rsp_overflow,
   output int                         fail_count,
   output int                         pending_count,
   output int                         beat_count,
   output int                         result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ede_pkg::DIST_W-1:0] distance;
      logic                       overflow;
   } score_type;

   logic [ede_pkg::CHAR_W-1:0] word_a [MAX_LEN];
   logic [ede_pkg::CHAR_W-1:0] word_b [MAX_LEN];
   int                len_a;
   int                len_b;
   logic              truncated;
   score_type         score_queue [$];
   int                fails;
   int                beats;
   int                results;

   function automatic logic [ede_pkg::DIST_W-1:0] edit_distance();
      int row [0:MAX_LEN];
      int diag;
      int up;
      int best;
      for (int j = 0; j <= len_b; j++) row[j] = j;
      for (int i = 1; i <= len_a; i++) begin
         diag = row[0];
         row[0] = i;
         for (int j = 1; j <= len_b; j++) begin
            up = row[j];
            if (word_a[i-1] == word_b[j-1]) begin
               row[j] = diag;
            end else begin
               best = (diag < up) ? diag : up;
               if (row[j-1] < best) best = row[j-1];
               row[j] = best + 1;
            end
            diag = up;
         end
      end
      if (row[len_b] > ede_pkg::DIST_MAX) return ede_pkg::DIST_W'(ede_pkg::DIST_MAX);
      return ede_pkg::DIST_W'(row[len_b]);
   endfunction

   always @(posedge clock) begin
      score_type predicted;
      if (reset) begin
         len_a = 0;
         len_b = 0;
         truncated = 1'b0;
         score_queue.delete();
         fails = 0;
         beats = 0;
         results = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results++;
            if (score_queue.size() == 0) begin
               $error("unexpected result beat: distance %0d overflow %0d",
                      rsp_distance, rsp_overflow);
               fails++;
            end else begin
               predicted = score_queue.pop_front();
               if (rsp_distance !== predicted.distance) begin
                  $error("distance: expected %0d, actual %0d",
                         predicted.distance, rsp_distance);
                  fails++;
               end
               if (rsp_overflow !== predicted.overflow) begin
                  $error("overflow: expected %0d, actual %0d",
                         predicted.overflow, rsp_overflow);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            beats++;
            case (req_operation)
               ede_pkg::OP_APPEND_FIRST: begin
                  if (len_a < MAX_LEN) begin
                     word_a[len_a] = req_char_byte;
                     len_a++;
                  end else begin
                     truncated = 1'b1;
                  end
               end
               ede_pkg::OP_APPEND_SECOND: begin
                  if (len_b < MAX_LEN) begin
                     word_b[len_b] = req_char_byte;
                     len_b++;
                  end else begin
                     truncated = 1'b1;
                  end
               end
               ede_pkg::OP_COMPUTE: begin
                  predicted.distance = edit_distance();
                  predicted.overflow = truncated;
                  score_queue.push_back(predicted);
                  len_a = 0;
                  len_b = 0;
                  truncated = 1'b0;
               end
               default: ;
            endcase
         end
      end
      fail_count    <= fails;
      pending_count <= score_queue.size();
      beat_count    <= beats;
      result_count  <= results;
   end

endmodule

// File: tb/edit_distance_engine_test.sv
// Top of the edit distance engine testbench: clock, reset, request stimulus and
// randomized response backpressure, with the verdict taken from edit_distance_checker.
// Depends on ede_pkg, edit_distance_engine and edit_distance_checker.
module edit_distance_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                        WORD_LIMIT   = ede_pkg::MAX_LEN_DEFAULT;
   localparam logic [ede_pkg::OP_W-1:0]  OP_UNUSED    = 2'd3;
   localparam int                        PHASE_ITEMS  = 500;
   localparam int                        CYCLE_LIMIT  = 2_000_000;
   localparam int                        DRAIN_CYCLES = WORD_LIMIT * (WORD_LIMIT + 1) + 64;

   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic [ede_pkg::OP_W-1:0]   req_operation = '0;
   logic [ede_pkg::CHAR_W-1:0] req_char_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic [ede_pkg::DIST_W-1:0] rsp_distance;
   logic                       rsp_overflow;

   int fail_count;
   int pending_count;
   int beat_count;
   int result_count;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   edit_distance_engine #(.MAX_LEN(WORD_LIMIT)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_char_byte(req_char_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

   edit_distance_checker #(.MAX_LEN(WORD_LIMIT)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_char_byte(req_char_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .beat_count   (beat_count),
      .result_count (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready   <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_beat(input logic [ede_pkg::OP_W-1:0] op,
                            input logic [ede_pkg::CHAR_W-1:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_char_byte <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(10);
      if (r < 96) return $urandom_range(30, 11);
      return $urandom_range(WORD_LIMIT + 3, 31);
   endfunction

   function automatic logic [ede_pkg::CHAR_W-1:0] pick_char(
      input bit full_range, input logic [ede_pkg::CHAR_W-1:0] base);
      if (full_range) return ede_pkg::CHAR_W'($urandom_range(255));
      return base + ede_pkg::CHAR_W'($urandom_range(2));
   endfunction

   task automatic send_pair(input int len_a, input int len_b, output int sent);
      logic [ede_pkg::CHAR_W-1:0] word_a [$];
      logic [ede_pkg::CHAR_W-1:0] word_b [$];
      logic [ede_pkg::CHAR_W-1:0] base;
      bit                         full_range;
      int                         ia;
      int                         ib;
      int                         r;
      full_range = $urandom_range(3) == 0;
      base = ede_pkg::CHAR_W'($urandom_range(255));
      for (int k = 0; k < len_a; k++) word_a.push_back(pick_char(full_range, base));
      if ($urandom_range(1) == 1) begin
         foreach (word_a[k]) begin
            r = $urandom_range(9);
            if (r == 1) begin
               word_b.push_back(pick_char(full_range, base));
            end else if (r == 2) begin
               word_b.push_back(pick_char(full_range, base));
               word_b.push_back(word_a[k]);
            end else if (r != 0) begin
               word_b.push_back(word_a[k]);
            end
         end
      end else begin
         for (int k = 0; k < len_b; k++) word_b.push_back(pick_char(full_range, base));
      end
      ia = 0;
      ib = 0;
      sent = 0;
      while (ia < word_a.size() || ib < word_b.size()) begin
         if ($urandom_range(99) < 3) begin
            send_beat(OP_UNUSED, ede_pkg::CHAR_W'($urandom_range(255)));
         end else if (ib == word_b.size() || (ia < word_a.size() && $urandom_range(1))) begin
            send_beat(ede_pkg::OP_APPEND_FIRST, word_a[ia]);
            ia++;
            sent++;
         end else begin
            send_beat(ede_pkg::OP_APPEND_SECOND, word_b[ib]);
            ib++;
            sent++;
         end
      end
      send_beat(ede_pkg::OP_COMPUTE, ede_pkg::CHAR_W'($urandom_range(255)));
      sent++;
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int sent;
      int n;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      send_pair(WORD_LIMIT + $urandom_range(2), $urandom_range(WORD_LIMIT + 2), n);
      sent = n;
      while (sent < PHASE_ITEMS) begin
         send_pair(pick_length(), pick_length(), n);
         sent += n;
      end
      wait_for_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(ede_pkg::OP_COMPUTE, 8'h00);
      send_beat(ede_pkg::OP_APPEND_FIRST, 8'h00);
      send_beat(ede_pkg::OP_COMPUTE, 8'hFF);
      send_beat(ede_pkg::OP_APPEND_SECOND, 8'hFF);
      send_beat(ede_pkg::OP_APPEND_SECOND, 8'h00);
      send_beat(ede_pkg::OP_COMPUTE, 8'h00);
      send_beat(OP_UNUSED, 8'hFF);
      send_beat(OP_UNUSED, 8'h00);
      send_beat(ede_pkg::OP_COMPUTE, 8'h00);
      send_beat(ede_pkg::OP_APPEND_FIRST, 8'hFF);
      send_beat(ede_pkg::OP_APPEND_SECOND, 8'hFF);
      send_beat(ede_pkg::OP_COMPUTE, 8'h00);
      send_beat(ede_pkg::OP_APPEND_FIRST, 8'h5A);
      send_beat(ede_pkg::OP_APPEND_SECOND, 8'hA5);
      send_beat(ede_pkg::OP_COMPUTE, 8'h00);
      send_beat(ede_pkg::OP_APPEND_FIRST, 8'h61);
      send_beat(ede_pkg::OP_APPEND_FIRST, 8'h62);
      send_beat(ede_pkg::OP_APPEND_SECOND, 8'h62);
      send_beat(ede_pkg::OP_APPEND_SECOND, 8'h61);
      send_beat(ede_pkg::OP_COMPUTE, 8'h00);
      wait_for_results();

      run_phase(0, 0);
      run_phase(68, 0);
      run_phase(0, 68);
      run_phase(18, 18);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d request beats and %0d checked distances across directed cases",
               beat_count, result_count);
      $display("and four pacing phases, including truncated words and unused operations.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: edit_distance_engine.f
design/ede_pkg.sv
design/ede_ctrl.sv
design/ede_datapath.sv
design/edit_distance_engine.sv
tb/edit_distance_checker.sv
tb/edit_distance_engine_test.sv
